/* rtl/fcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_pkg: shared types and constants of the fuzzy completion scorer
// Command codes, queue beat formats and the per-byte scoring function.
// ----------------------------------------------------------------------------
package fcs_pkg;

	localparam int QUERY_MAX = 128;
	localparam int WORD_MAX  = 255;
	localparam int LIST_MAX  = 1024;

	localparam int QA_W  = $clog2(QUERY_MAX);
	localparam int QL_W  = $clog2(QUERY_MAX + 1);
	localparam int WL_W  = $clog2(WORD_MAX + 1);
	localparam int WC_W  = (LIST_MAX > 1) ? $clog2(LIST_MAX) : 1;
	localparam int IDX_W = 10;
	localparam int SC_W  = 13;
	localparam int BS_W  = 12;
	localparam int ERR_W = 5;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	localparam logic [7:0] CASE_MASK = 8'hDF;
	localparam logic [7:0] SEP_MAX   = 8'd32;
	localparam logic [7:0] SPACE     = 8'h20;
	localparam logic [7:0] NUL       = 8'h00;

	localparam logic signed [SC_W-1:0]  PTS_LEAD  = 13'sd10;
	localparam logic signed [SC_W-1:0]  PTS_RUN   = 13'sd5;
	localparam logic signed [SC_W-1:0]  PTS_MISS  = 13'sd1;
	localparam logic signed [ERR_W-1:0] ERR_STEP  = 5'sd3;
	localparam logic signed [ERR_W-1:0] ERR_FLOOR = -5'sd9;
	localparam logic signed [ERR_W-1:0] ERR_LIM   = ERR_FLOOR + ERR_STEP;

	typedef enum logic [1:0] {
		CMD_QUERY = 2'd0,
		CMD_WORD  = 2'd1,
		CMD_EMPTY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t       kind;
		logic [7:0] ch;
		logic       first;
		logic       last_char;
		logic       last_word;
	} op_t;

	typedef struct packed {
		logic [IDX_W-1:0]       word_index;
		logic signed [SC_W-1:0] word_score;
		logic                   best_found;
		logic [IDX_W-1:0]       best_index;
		logic [BS_W-1:0]        best_score;
		logic                   list_done;
	} res_t;

	// running scan state of one word
	typedef struct packed {
		logic [QL_W-1:0]         pos;
		logic [7:0]              prev;
		logic                    am;
		logic signed [SC_W-1:0]  run;
		logic signed [ERR_W-1:0] err;
		logic                    hit;
	} scan_t;

	function automatic scan_t score_byte(input scan_t s, input logic [7:0] c,
			input logic [7:0] nxt, input logic [7:0] q, input logic [QL_W-1:0] len);
		scan_t r;
		logic  lead;
		logic  sep;
		r = s;
		r.hit = 1'b0;
		lead = c[6] & ~nxt[6];
		sep = (s.prev <= SEP_MAX) || s.prev[7];
		if (s.pos < len) begin
			if (((c ^ q) & CASE_MASK) == NUL) begin
				if (sep || lead) begin
					r.run = s.run + PTS_LEAD;
				end else if (s.am) begin
					r.run = s.run + PTS_RUN;
				end
				r.am = 1'b1;
				r.hit = 1'b1;
				r.pos = s.pos + QL_W'(1);
			end else begin
				r.run = s.run - PTS_MISS;
				r.am = 1'b0;
				if (lead) begin
					r.err = (s.err < ERR_LIM) ? ERR_FLOOR : s.err - ERR_STEP;
				end
			end
		end
		r.prev = c;
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] to_idx(input logic [WC_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[IDX_W-1:0];
	endfunction

	function automatic logic [WC_W-1:0] next_cnt(input logic [WC_W-1:0] v);
		if (32'(v) == LIST_MAX - 1) begin
			return '0;
		end
		return v + WC_W'(1);
	endfunction

endpackage

/* rtl/fuzzy_completion_scorer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_completion_scorer_top: fuzzy subsequence scorer for a word list
// Loads a query, scores streamed candidate words, tracks the best word.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive command, character, first, last_char and
//   last_word with push; a beat is taken when push is high and full is low.
//   Query bytes (command 0) and word bytes (command 1) may be mixed freely;
//   command 2 scores an empty word, command 3 is dropped.
//   Result side is a queue: while empty is low the oldest word result is on
//   the result ports; it is taken when pop is high. One result per word, on
//   the beat carrying last_char or on an empty-word beat.
//   Throughput is one beat per cycle while the result queue has room, set by
//   the scoring update in the back stage (two byte scores and one query
//   memory read per cycle).
//   A stalled receiver fills the 4-entry result queue, then the back stops
//   and the 4-entry op queue fills, after which full is raised.
//   Reset empties both queues, the query and all word and list state; the
//   query memory itself is not cleared, only its written entries are read.
// ----------------------------------------------------------------------------
module fuzzy_completion_scorer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [1:0]                        command,
	input  logic [7:0]                        character,
	input  logic                              first,
	input  logic                              last_char,
	input  logic                              last_word,
	output logic                              empty,
	input  logic                              pop,
	output logic [fcs_pkg::IDX_W-1:0]         word_index,
	output logic signed [fcs_pkg::SC_W-1:0]   word_score,
	output logic                              best_found,
	output logic [fcs_pkg::IDX_W-1:0]         best_index,
	output logic [fcs_pkg::BS_W-1:0]          best_score,
	output logic                              list_done
);
	import fcs_pkg::*;

	op_t  op;
	logic op_valid;
	logic op_ready;
	res_t res;
	logic res_valid;

	fcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.character (character),
		.first     (first),
		.last_char (last_char),
		.last_word (last_word),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op)
	);

	fcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op),
		.res_valid (res_valid),
		.res_pop   (pop),
		.res       (res)
	);

	assign empty      = !res_valid;
	assign word_index = res.word_index;
	assign word_score = res.word_score;
	assign best_found = res.best_found;
	assign best_index = res.best_index;
	assign best_score = res.best_score;
	assign list_done  = res.list_done;

endmodule

/* rtl/fcs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_front: input classification and op queue
// Takes input beats, drops unused commands and queues the rest for the back.
// ----------------------------------------------------------------------------
module fcs_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [1:0]   command,
	input  logic [7:0]   character,
	input  logic         first,
	input  logic         last_char,
	input  logic         last_word,
	output logic         op_valid,
	input  logic         op_ready,
	output fcs_pkg::op_t op
);
	import fcs_pkg::*;

	op_t              oq [OQ_DEPTH];
	logic [OQ_AW-1:0] wp_q;
	logic [OQ_AW-1:0] rp_q;
	logic [OQ_AW:0]   cnt_q;
	logic             keep;
	logic             acc;
	logic             wr;
	logic             rd;
	op_t              op_in;

	always_comb begin
		unique case (cmd_t'(command)) inside
			CMD_QUERY, CMD_WORD, CMD_EMPTY: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	assign op_in = '{kind: cmd_t'(command), ch: character, first: first,
		last_char: last_char, last_word: last_word};

	assign full     = (cnt_q == (OQ_AW + 1)'(OQ_DEPTH));
	assign acc      = push && !full;
	assign wr       = acc && keep;
	assign op_valid = (cnt_q != '0);
	assign rd       = op_valid && op_ready;
	assign op       = oq[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			oq[wp_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + OQ_AW'(1);
			end
			if (rd) begin
				rp_q <= rp_q + OQ_AW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + (OQ_AW + 1)'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - (OQ_AW + 1)'(1);
			end
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (OQ_AW + 1)'(OQ_DEPTH))
		else $error("op queue overfilled");
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> cnt_q == $past(cnt_q) + (OQ_AW + 1)'(1))
		else $error("queued beat lost");
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !keep && !rd) |=> $stable(cnt_q))
		else $error("unused command was queued");
`endif

endmodule

/* rtl/fcs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_back: query store, word scoring and best-word tracking
// Executes one queued op per cycle while the result queue has room, and queues one result per finished word.
// ----------------------------------------------------------------------------
module fcs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	output logic          op_ready,
	input  fcs_pkg::op_t  op,
	output logic          res_valid,
	input  logic          res_pop,
	output fcs_pkg::res_t res
);
	import fcs_pkg::*;

	// query memory, registered read at query position plus one
	logic [7:0]      qmem [QUERY_MAX];
	logic [7:0]      rd_q;
	logic            byp_v_q;
	logic [7:0]      byp_d_q;
	logic [7:0]      qcur_q;
	logic [7:0]      q0_q;
	logic [QA_W-1:0] ra;

	logic [QL_W-1:0]         len_q, len_n;
	logic [QL_W-1:0]         pos_q, pos_n;
	logic [7:0]              pend_q, pend_n;
	logic                    pv_q, pv_n;
	logic [7:0]              prev_q, prev_n;
	logic                    am_q, am_n;
	logic signed [SC_W-1:0]  run_q, run_n;
	logic signed [ERR_W-1:0] err_q, err_n;
	logic [WL_W-1:0]         wlen_q, wlen_n;
	logic [WC_W-1:0]         wcnt_q, wcnt_n;
	logic [IDX_W-1:0]        bestw_q, bestw_n;
	logic [BS_W-1:0]         bestv_q, bestv_n;
	logic [WL_W-1:0]         bestl_q, bestl_n;
	logic                    have_q, have_n;
	logic [7:0]              qcur_n, q0_n;

	logic                    take;
	logic                    mem_we;
	logic [QA_W-1:0]         mem_wa;
	logic [QL_W-1:0]         base;
	logic [7:0]              qnext, qa, qb;
	logic                    wc;
	scan_t                   s0, s1, s2;
	logic                    pv0, pv1, acc_b;
	logic [WL_W-1:0]         wl0, wl1;
	logic [7:0]              pend1;
	logic [WC_W-1:0]         wcnt0;
	logic [IDX_W-1:0]        bestw0;
	logic [BS_W-1:0]         bestv0;
	logic [WL_W-1:0]         bestl0;
	logic                    have0;
	logic                    fin;
	logic signed [SC_W-1:0]  fin_run;
	logic signed [ERR_W-1:0] fin_err;
	logic [WL_W-1:0]         fin_wl;
	logic signed [SC_W-1:0]  total;
	logic                    pick;
	logic                    res_push;
	res_t                    res_d;

	// result queue
	res_t             rq [RQ_DEPTH];
	logic [RQ_AW-1:0] rq_wp_q;
	logic [RQ_AW-1:0] rq_rp_q;
	logic [RQ_AW:0]   rq_cnt_q;
	logic             rq_pop;

	assign op_ready  = (rq_cnt_q != (RQ_AW + 1)'(RQ_DEPTH));
	assign take      = op_valid && op_ready;
	assign res_valid = (rq_cnt_q != '0);
	assign rq_pop    = res_pop && res_valid;
	assign res       = rq[rq_rp_q];
	assign qnext     = byp_v_q ? byp_d_q : rd_q;

	always_comb begin
		len_n   = len_q;
		pos_n   = pos_q;
		pend_n  = pend_q;
		pv_n    = pv_q;
		prev_n  = prev_q;
		am_n    = am_q;
		run_n   = run_q;
		err_n   = err_q;
		wlen_n  = wlen_q;
		wcnt_n  = wcnt_q;
		bestw_n = bestw_q;
		bestv_n = bestv_q;
		bestl_n = bestl_q;
		have_n  = have_q;
		qcur_n  = qcur_q;
		q0_n    = q0_q;
		mem_we  = 1'b0;
		mem_wa  = '0;
		base    = '0;
		fin     = 1'b0;
		fin_run = '0;
		fin_err = '0;
		fin_wl  = '0;
		pick    = 1'b0;
		total   = '0;
		res_push = 1'b0;
		res_d   = '0;

		// word and list state as seen after a first mark
		wc = op.first || (op.kind == CMD_EMPTY);
		s0.pos  = wc ? '0 : pos_q;
		s0.prev = wc ? SPACE : prev_q;
		s0.am   = wc ? 1'b0 : am_q;
		s0.run  = wc ? '0 : run_q;
		s0.err  = wc ? '0 : err_q;
		s0.hit  = 1'b0;
		pv0     = wc ? 1'b0 : pv_q;
		wl0     = wc ? '0 : wlen_q;
		qa      = wc ? q0_q : qcur_q;
		wcnt0   = op.first ? '0 : wcnt_q;
		bestw0  = op.first ? '0 : bestw_q;
		bestv0  = op.first ? '0 : bestv_q;
		bestl0  = op.first ? '0 : bestl_q;
		have0   = op.first ? 1'b0 : have_q;

		// lookahead: the held byte is scored now, the new byte is held
		acc_b = (32'(wl0) < WORD_MAX);
		s1 = s0;
		if (acc_b && pv0) begin
			s1 = score_byte(s0, pend_q, op.ch, qa, len_q);
		end
		pend1 = acc_b ? op.ch : pend_q;
		pv1   = pv0 | acc_b;
		wl1   = acc_b ? wl0 + WL_W'(1) : wl0;
		qb    = s1.hit ? qnext : qa;
		s2 = s1;
		if (pv1) begin
			s2 = score_byte(s1, pend1, NUL, qb, len_q);
		end

		if (take) begin
			unique case (op.kind)
				CMD_QUERY: begin
					base  = op.first ? '0 : len_q;
					len_n = base;
					if (op.ch != NUL && 32'(base) < QUERY_MAX) begin
						mem_we = 1'b1;
						mem_wa = QA_W'(base);
						len_n  = base + QL_W'(1);
						if (base == pos_q) begin
							qcur_n = op.ch;
						end
						if (base == '0) begin
							q0_n = op.ch;
						end
					end
				end
				CMD_WORD: begin
					wcnt_n  = wcnt0;
					bestw_n = bestw0;
					bestv_n = bestv0;
					bestl_n = bestl0;
					have_n  = have0;
					if (op.last_char) begin
						fin     = 1'b1;
						fin_run = s2.run;
						fin_err = s2.err;
						fin_wl  = wl1;
					end else begin
						pos_n  = s1.pos;
						prev_n = s1.prev;
						am_n   = s1.am;
						run_n  = s1.run;
						err_n  = s1.err;
						pend_n = pend1;
						pv_n   = pv1;
						wlen_n = wl1;
						qcur_n = qb;
					end
				end
				CMD_EMPTY: begin
					fin = 1'b1;
				end
				default: ;
			endcase
		end

		if (fin) begin
			total = fin_run + SC_W'(fin_err);
			pick = !total[SC_W-1] && (!have0 || total[BS_W-1:0] > bestv0 ||
				(total[BS_W-1:0] == bestv0 && !(bestl0 < fin_wl)));
			have_n  = have0 | pick;
			bestw_n = pick ? to_idx(wcnt0) : bestw0;
			bestv_n = pick ? total[BS_W-1:0] : bestv0;
			bestl_n = pick ? fin_wl : bestl0;
			res_push = 1'b1;
			res_d.word_index = to_idx(wcnt0);
			res_d.word_score = total;
			res_d.best_found = have_n;
			res_d.best_index = bestw_n;
			res_d.best_score = bestv_n;
			res_d.list_done  = op.last_word;
			wcnt_n = next_cnt(wcnt0);
			pos_n  = '0;
			pend_n = NUL;
			pv_n   = 1'b0;
			prev_n = SPACE;
			am_n   = 1'b0;
			run_n  = '0;
			err_n  = '0;
			wlen_n = '0;
			qcur_n = q0_q;
		end

		ra = QA_W'(pos_n + QL_W'(1));
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			qmem[mem_wa] <= op.ch;
		end
		rd_q    <= qmem[ra];
		byp_d_q <= op.ch;
		qcur_q  <= qcur_n;
		q0_q    <= q0_n;
		if (res_push) begin
			rq[rq_wp_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_v_q  <= 1'b0;
			len_q    <= '0;
			pos_q    <= '0;
			pend_q   <= NUL;
			pv_q     <= 1'b0;
			prev_q   <= SPACE;
			am_q     <= 1'b0;
			run_q    <= '0;
			err_q    <= '0;
			wlen_q   <= '0;
			wcnt_q   <= '0;
			bestw_q  <= '0;
			bestv_q  <= '0;
			bestl_q  <= '0;
			have_q   <= 1'b0;
			rq_wp_q  <= '0;
			rq_rp_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			// write into the entry being prefetched: forward the new byte
			byp_v_q  <= mem_we && (mem_wa == ra);
			len_q    <= len_n;
			pos_q    <= pos_n;
			pend_q   <= pend_n;
			pv_q     <= pv_n;
			prev_q   <= prev_n;
			am_q     <= am_n;
			run_q    <= run_n;
			err_q    <= err_n;
			wlen_q   <= wlen_n;
			wcnt_q   <= wcnt_n;
			bestw_q  <= bestw_n;
			bestv_q  <= bestv_n;
			bestl_q  <= bestl_n;
			have_q   <= have_n;
			if (res_push) begin
				rq_wp_q <= rq_wp_q + RQ_AW'(1);
			end
			if (rq_pop) begin
				rq_rp_q <= rq_rp_q + RQ_AW'(1);
			end
			if (res_push && !rq_pop) begin
				rq_cnt_q <= rq_cnt_q + (RQ_AW + 1)'(1);
			end else if (rq_pop && !res_push) begin
				rq_cnt_q <= rq_cnt_q - (RQ_AW + 1)'(1);
			end
		end
	end

`ifndef SYNTH
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(len_q) <= QUERY_MAX)
		else $error("query length past capacity");
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		err_q >= ERR_FLOOR && err_q <= 5'sd0)
		else $error("error sum out of range");
	a_rq_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> rq_cnt_q != (RQ_AW + 1)'(RQ_DEPTH))
		else $error("result queue overrun");
	a_pend_len: assert property (@(posedge clk) disable iff (!arst_n)
		pv_q |-> (wlen_q != '0 && 32'(wlen_q) <= WORD_MAX))
		else $error("held byte without word length");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: fuzzy completion scorer
// Loads queries and streams word lists through the input queue. A scoring
// model built into the bench predicts each word result. Results drained from
// the output queue are compared field by field, in order, under random
// stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import fcs_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_REPORTS  = 40;

	localparam int LEAD_PTS      = 10;
	localparam int RUN_PTS       = 5;
	localparam int MISS_PTS      = 1;
	localparam int ERR_STEP_PTS  = 3;
	localparam int ERR_FLOOR_PTS = -9;

	localparam logic [7:0] CASE_BITS = 8'hDF;
	localparam logic [7:0] SEP_LIMIT = 8'd32;
	localparam logic [7:0] BLANK     = 8'h20;
	localparam logic [7:0] ZERO_CHAR = 8'h00;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [1:0]        command = CMD_NONE;
	logic [7:0]        character = 8'h00;
	logic              first = 1'b0;
	logic              last_char = 1'b0;
	logic              last_word = 1'b0;
	logic              empty;
	logic              pop = 1'b0;
	logic [IDX_W-1:0]  word_index;
	logic signed [SC_W-1:0] word_score;
	logic              best_found;
	logic [IDX_W-1:0]  best_index;
	logic [BS_W-1:0]   best_score;
	logic              list_done;

	// scoring state of the bench model
	logic [7:0] query_mem [QUERY_MAX];
	int         query_len = 0;
	int         match_pos = 0;
	logic [7:0] held_char = 8'h00;
	bit         held_valid = 1'b0;
	logic [7:0] prior_char = BLANK;
	bit         in_run = 1'b0;
	int         word_pts = 0;
	int         miss_penalty = 0;
	int         char_count = 0;
	int         word_no = 0;
	int         top_word = 0;
	int         top_score = 0;
	int         top_length = 0;
	bit         have_top = 1'b0;

	res_t       due_results[$];

	int         beats_sent = 0;
	int         mismatches = 0;
	int         cycle_count = 0;
	int         send_idle_pct = 0;
	int         pop_idle_pct = 0;

	fuzzy_completion_scorer_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.character  (character),
		.first      (first),
		.last_char  (last_char),
		.last_word  (last_word),
		.empty      (empty),
		.pop        (pop),
		.word_index (word_index),
		.word_score (word_score),
		.best_found (best_found),
		.best_index (best_index),
		.best_score (best_score),
		.list_done  (list_done)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// scoring model
	// ------------------------------------------------------------------
	task automatic restart_word();
		match_pos = 0;
		held_char = 8'h00;
		held_valid = 1'b0;
		prior_char = BLANK;
		in_run = 1'b0;
		word_pts = 0;
		miss_penalty = 0;
		char_count = 0;
	endtask

	task automatic rate_char(logic [7:0] c, logic [7:0] nxt);
		bit lead;
		bit sep;
		lead = c[6] && !nxt[6];
		sep = (prior_char <= SEP_LIMIT) || prior_char[7];
		if (match_pos < query_len) begin
			if (((c ^ query_mem[match_pos]) & CASE_BITS) == ZERO_CHAR) begin
				if (sep || lead) begin
					word_pts += LEAD_PTS;
				end else if (in_run) begin
					word_pts += RUN_PTS;
				end
				in_run = 1'b1;
				match_pos++;
			end else begin
				word_pts -= MISS_PTS;
				in_run = 1'b0;
				if (lead) begin
					miss_penalty -= ERR_STEP_PTS;
					if (miss_penalty < ERR_FLOOR_PTS)
						miss_penalty = ERR_FLOOR_PTS;
				end
			end
		end
		prior_char = c;
	endtask

	task automatic close_word(bit lw);
		int   total;
		bit   take;
		res_t r;
		total = word_pts + miss_penalty;
		if (total < 0)
			take = 1'b0;
		else if (!have_top || total > top_score)
			take = 1'b1;
		else if (total == top_score)
			take = !(top_length < char_count);
		else
			take = 1'b0;
		if (take) begin
			have_top = 1'b1;
			top_score = total;
			top_word = word_no;
			top_length = char_count;
		end
		r.word_index = IDX_W'(word_no);
		r.word_score = SC_W'(total);
		r.best_found = have_top;
		r.best_index = have_top ? IDX_W'(top_word) : '0;
		r.best_score = have_top ? BS_W'(top_score) : '0;
		r.list_done = lw;
		due_results.push_back(r);
		word_no = (word_no + 1) % LIST_MAX;
		restart_word();
	endtask

	task automatic score_beat(cmd_t cmd, logic [7:0] ch, bit fst, bit lc, bit lw);
		case (cmd) inside
			CMD_QUERY: begin
				if (fst)
					query_len = 0;
				if (ch != ZERO_CHAR && query_len < QUERY_MAX) begin
					query_mem[query_len] = ch;
					query_len++;
				end
			end
			CMD_WORD, CMD_EMPTY: begin
				if (fst) begin
					word_no = 0;
					top_word = 0;
					top_score = 0;
					top_length = 0;
					have_top = 1'b0;
					restart_word();
				end
				if (cmd == CMD_EMPTY) begin
					restart_word();
					close_word(lw);
				end else begin
					// a byte is scored once the next one shows whether it leads
					if (char_count < WORD_MAX) begin
						if (held_valid)
							rate_char(held_char, ch);
						held_char = ch;
						held_valid = 1'b1;
						char_count++;
					end
					if (lc) begin
						if (held_valid)
							rate_char(held_char, ZERO_CHAR);
						close_word(lw);
					end
				end
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------
	task automatic push_beat(cmd_t cmd, logic [7:0] ch, bit fst, bit lc, bit lw);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		command <= cmd;
		character <= ch;
		first <= fst;
		last_char <= lc;
		last_word <= lw;
		@(posedge clk);
		while (full)
			@(posedge clk);
		score_beat(cmd, ch, fst, lc, lw);
		beats_sent++;
	endtask

	function automatic logic [7:0] rand_letter();
		int span;
		span = ($urandom_range(9) == 0) ? $urandom_range(25) : $urandom_range(7);
		return (8'h61 + 8'(span)) ^ ($urandom_range(1) ? 8'h20 : 8'h00);
	endfunction

	function automatic logic [7:0] pick_query_byte();
		int r;
		r = $urandom_range(99);
		if (r < 88)
			return rand_letter();
		else if (r < 94)
			return 8'($urandom_range(1, 255));
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] pick_word_byte(int match_pct);
		int r;
		r = $urandom_range(99);
		// bias toward the next query byte so that scans get deep
		if (r < match_pct && match_pos < query_len)
			return query_mem[match_pos] ^ ($urandom_range(1) ? 8'h20 : 8'h00);
		if (r < match_pct + 10 && query_len > 0)
			return query_mem[$urandom_range(query_len - 1)];
		r = $urandom_range(99);
		if (r < 55)
			return rand_letter();
		else if (r < 70)
			return 8'h30 + 8'($urandom_range(9));
		else if (r < 80)
			return $urandom_range(1) ? BLANK : 8'h5F;
		else if (r < 88)
			return 8'($urandom_range(128, 255));
		else if (r < 92)
			return ZERO_CHAR;
		return 8'($urandom_range(255));
	endfunction

	task automatic load_query(int len);
		int i;
		if (len == 0)
			push_beat(CMD_QUERY, ZERO_CHAR, 1'b1, bit'($urandom_range(1)),
				bit'($urandom_range(1)));
		for (i = 0; i < len; i++)
			push_beat(CMD_QUERY, pick_query_byte(), i == 0, bit'($urandom_range(1)),
				bit'($urandom_range(1)));
	endtask

	task automatic send_word(int len, bit fst, bit lw, int noise_pct, int match_pct);
		int i;
		if (len == 0)
			push_beat(CMD_EMPTY, 8'($urandom_range(255)), fst, bit'($urandom_range(1)),
				lw);
		for (i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(99) < noise_pct) begin
				case (cmd_t'($urandom_range(3)))
					CMD_NONE: push_beat(CMD_NONE, 8'($urandom_range(255)),
						bit'($urandom_range(1)), bit'($urandom_range(1)),
						bit'($urandom_range(1)));
					CMD_QUERY: push_beat(CMD_QUERY, pick_query_byte(),
						$urandom_range(9) == 0, bit'($urandom_range(1)),
						bit'($urandom_range(1)));
					CMD_EMPTY: push_beat(CMD_EMPTY, 8'($urandom_range(255)), 1'b0,
						bit'($urandom_range(1)), bit'($urandom_range(1)));
					default: push_beat(CMD_WORD, pick_word_byte(match_pct), 1'b1, 1'b0,
						bit'($urandom_range(1)));
				endcase
			end
			push_beat(CMD_WORD, pick_word_byte(match_pct), fst && i == 0, i == len - 1,
				(i == len - 1) ? lw : bit'($urandom_range(1)));
		end
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------
	task automatic compare_field(string field, int want, int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result beat expected none actual word_index %0d",
						$time, word_index);
			end else begin
				want = due_results.pop_front();
				compare_field("word_index", int'(want.word_index), int'(word_index));
				compare_field("word_score", int'(want.word_score), int'(word_score));
				compare_field("best_found", int'(want.best_found), int'(best_found));
				compare_field("best_index", int'(want.best_index), int'(best_index));
				compare_field("best_score", int'(want.best_score), int'(best_score));
				compare_field("list_done", int'(want.list_done), int'(list_done));
			end
		end
		pop <= arst_n && ($urandom_range(99) >= pop_idle_pct);
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_ignored_command();
		push_beat(CMD_NONE, 8'hFF, 1'b1, 1'b1, 1'b1);
	endtask

	// nothing loaded yet, so every byte is skipped and the word scores zero
	task automatic test_empty_query();
		push_beat(CMD_WORD, 8'h41, 1'b1, 1'b0, 1'b0);
		push_beat(CMD_WORD, 8'h62, 1'b0, 1'b1, 1'b0);
	endtask

	task automatic test_query_load();
		push_beat(CMD_QUERY, ZERO_CHAR, 1'b1, 1'b0, 1'b0);
		push_beat(CMD_QUERY, 8'h66, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_QUERY, 8'h42, 1'b0, 1'b0, 1'b0);
	endtask

	task automatic test_separators();
		push_beat(CMD_WORD, 8'hFF, 1'b1, 1'b0, 1'b0);
		push_beat(CMD_WORD, 8'h46, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_WORD, 8'h6F, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_WORD, ZERO_CHAR, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_WORD, 8'h62, 1'b0, 1'b1, 1'b0);
	endtask

	// leading misses pile up past the floor
	task automatic test_error_clamp();
		push_beat(CMD_WORD, 8'h61, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_WORD, 8'h31, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_WORD, 8'h63, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_WORD, 8'h32, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_WORD, 8'h64, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_WORD, 8'h33, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_WORD, 8'h65, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_WORD, 8'h34, 1'b0, 1'b1, 1'b0);
	endtask

	task automatic test_empty_word();
		push_beat(CMD_EMPTY, 8'h00, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_WORD, 8'h78, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_EMPTY, 8'hA5, 1'b0, 1'b1, 1'b0);
	endtask

	task automatic test_query_append_mid_word();
		push_beat(CMD_WORD, 8'h66, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_QUERY, 8'h6F, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_WORD, 8'h62, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_WORD, 8'h6F, 1'b0, 1'b1, 1'b1);
	endtask

	task automatic test_first_mid_word();
		push_beat(CMD_WORD, 8'h71, 1'b0, 1'b0, 1'b0);
		push_beat(CMD_WORD, 8'h66, 1'b1, 1'b1, 1'b1);
	endtask

	task automatic test_random_lists(int n_beats);
		int stop;
		int n_words;
		int w;
		int r;
		int len;
		stop = beats_sent + n_beats;
		while (beats_sent < stop) begin
			if ($urandom_range(99) < 30) begin
				r = $urandom_range(99);
				load_query(r < 4 ? 0 : r < 88 ? $urandom_range(1, 6) : $urandom_range(7, 40));
			end
			n_words = $urandom_range(1, 10);
			for (w = 0; w < n_words; w++) begin
				r = $urandom_range(99);
				len = r < 6 ? 0 : r < 85 ? $urandom_range(1, 10) : $urandom_range(11, 40);
				send_word(len, w == 0 && $urandom_range(99) < 85, w == n_words - 1, 4, 45);
			end
		end
	endtask

	// more appends than the query holds, then words that scan deep into it
	task automatic test_query_full();
		load_query(135);
		send_word(60, 1'b1, 1'b0, 0, 92);
		send_word(8, 1'b0, 1'b1, 0, 50);
	endtask

	task automatic test_long_word();
		load_query($urandom_range(2, 5));
		send_word(WORD_MAX + 3, 1'b1, 1'b1, 0, 30);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 10;
		pop_idle_pct = 58;
		test_ignored_command();
		test_empty_query();
		test_query_load();
		test_separators();
		test_error_clamp();
		test_empty_word();
		test_query_append_mid_word();
		test_first_mid_word();
		test_random_lists(30);

		send_idle_pct = 58;
		pop_idle_pct = 10;
		test_query_full();
		test_long_word();
		test_random_lists(30);

		send_idle_pct = 0;
		pop_idle_pct = 0;
		test_random_lists(30);

		push <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
